/* hdl/bfc_pkg.sv */
// ----------------------------------------------------------------------------
// bfc_pkg - shared types for the radio UART frame classifier
// Message kinds and the job descriptor that goes from the front end to the
// result sequencer.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // Kind of message carried by one result run
  typedef enum logic [2:0] {
    KIND_PWD   = 3'd0,
    KIND_PHONE = 3'd1,
    KIND_TIME  = 3'd2,
    KIND_MAC   = 3'd3,
    KIND_SCAN  = 3'd4
  } kind_t;

  // One classified frame: which bank holds it and how to walk its payload.
  // Run position c reads offset base_lo + c below position 6 and
  // base_hi + c from position 6 on.
  typedef struct packed {
    logic       bank;
    kind_t      kind;
    logic [3:0] last_idx;
    logic [5:0] base_lo;
    logic [5:0] base_hi;
    logic [5:0] len;
  } job_t;

  localparam int unsigned SPLIT_POS = 6;

endpackage

/* hdl/bfc_front.sv */
// ----------------------------------------------------------------------------
// bfc_front - byte intake and frame classification
// Stores frame bytes into the current buffer bank, snoops header, marker and
// tail bytes, and at frame end classifies the frame into a job descriptor.
// ----------------------------------------------------------------------------
module bfc_front #(
  parameter int FRAME_BYTES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [7:0]                            in_rx_byte,
  input  logic                                  in_frame_end,
  input  logic                                  q_full,
  output logic                                  wr_en,
  output logic [$clog2(FRAME_BYTES):0]          wr_addr,
  output logic [7:0]                            wr_data,
  output logic                                  push,
  output bfc_pkg::job_t                         push_job
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);

  // Snooped byte positions
  localparam int CAP_NUM = 14;
  localparam logic [5:0] CAP_POS [CAP_NUM] =
    '{6'd0, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
      6'd36, 6'd37, 6'd40};
  localparam int C_B0  = 0;
  localparam int C_B3  = 1;
  localparam int C_B4  = 2;
  localparam int C_B5  = 3;
  localparam int C_B6  = 4;
  localparam int C_B7  = 5;
  localparam int C_B26 = 6;
  localparam int C_B27 = 7;
  localparam int C_B28 = 8;
  localparam int C_B29 = 9;
  localparam int C_B30 = 10;
  localparam int C_B36 = 11;
  localparam int C_B37 = 12;
  localparam int C_B40 = 13;

  // Frame type codes at offset 26
  localparam logic [7:0] TYPE_PWD_A   = 8'h1A;
  localparam logic [7:0] TYPE_PHONE_A = 8'h0F;
  localparam logic [7:0] TYPE_TIME_A  = 8'h18;
  localparam logic [7:0] TYPE_PWD_B   = 8'h08;
  localparam logic [7:0] TYPE_TIME_B  = 8'h12;
  localparam logic [7:0] TYPE_PHONE_B = 8'h1E;
  localparam logic [7:0] HDR_BYTE     = 8'h4F;
  localparam logic [7:0] CR_BYTE      = 8'h0D;
  localparam logic [7:0] LF_BYTE      = 8'h0A;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             eval_r, eval_nxt;
  logic             bank_r, bank_nxt;
  logic [7:0]       tail0_r, tail0_nxt;
  logic [7:0]       tail1_r, tail1_nxt;
  logic [7:0]       cap_r [CAP_NUM];
  logic [7:0]       cap_nxt [CAP_NUM];

  logic accept;
  logic store;
  logic len_short, len_19, len_long, hdr_ok, tail_ok;

  assign busy   = eval_r | q_full;
  assign accept = start & ~busy;
  assign store  = accept & (count_r < CNT_W'(FRAME_BYTES));

  // Write the byte into the active bank
  assign wr_en   = store;
  assign wr_addr = {bank_r, count_r[IDX_W-1:0]};
  assign wr_data = in_rx_byte;

  // Length and framing checks
  assign len_19    = (count_r == CNT_W'(19));
  assign len_short = (count_r == CNT_W'(6)) || (count_r == CNT_W'(8));
  assign len_long  = (count_r == CNT_W'(37)) || (count_r == CNT_W'(44)) ||
                     (count_r == CNT_W'(47)) || (count_r == CNT_W'(53)) ||
                     (count_r == CNT_W'(55)) || (count_r == CNT_W'(59));
  assign hdr_ok    = (cap_r[C_B0] == HDR_BYTE);
  assign tail_ok   = (count_r >= CNT_W'(2)) && (tail0_r == CR_BYTE) &&
                     (tail1_r == LF_BYTE);

  // Classify the finished frame
  always_comb begin
    push     = 1'b0;
    push_job = '0;
    push_job.bank = bank_r;
    push_job.len  = count_r[5:0];
    if (eval_r && !ovf_r && hdr_ok && (len_short || len_19 || tail_ok)) begin
      if (len_long) begin
        case (cap_r[C_B26])
          TYPE_PWD_A: begin
            if (cap_r[C_B29] == 8'h57 && cap_r[C_B30] == 8'h5A) begin
              push              = 1'b1;
              push_job.kind     = bfc_pkg::KIND_PWD;
              push_job.last_idx = 4'd11;
              push_job.base_lo  = 6'd31;
              push_job.base_hi  = 6'd41;
            end
          end
          TYPE_PHONE_A: begin
            if (cap_r[C_B29] == 8'h77 && cap_r[C_B30] == 8'h7A) begin
              push              = 1'b1;
              push_job.kind     = bfc_pkg::KIND_PHONE;
              push_job.last_idx = 4'd10;
              push_job.base_lo  = 6'd31;
              push_job.base_hi  = 6'd31;
            end
          end
          TYPE_TIME_A: begin
            if (cap_r[C_B29] == 8'h49 && cap_r[C_B30] == 8'h54) begin
              push              = 1'b1;
              push_job.kind     = bfc_pkg::KIND_TIME;
              push_job.last_idx = 4'd13;
              push_job.base_lo  = 6'd31;
              push_job.base_hi  = 6'd31;
            end
          end
          TYPE_PWD_B: begin
            if (cap_r[C_B27] == 8'h07 && cap_r[C_B28] == 8'h09) begin
              push              = 1'b1;
              push_job.kind     = bfc_pkg::KIND_PWD;
              push_job.last_idx = 4'd11;
              push_job.base_lo  = 6'd29;
              push_job.base_hi  = 6'd23;
            end
          end
          TYPE_TIME_B: begin
            if (cap_r[C_B29] == 8'h54 && cap_r[C_B30] == 8'h49) begin
              push              = 1'b1;
              push_job.kind     = bfc_pkg::KIND_TIME;
              push_job.last_idx = 4'd13;
              push_job.base_lo  = 6'd31;
              push_job.base_hi  = 6'd31;
            end
          end
          TYPE_PHONE_B: begin
            if (cap_r[C_B36] == 8'h00 && cap_r[C_B37] == 8'h0A &&
                cap_r[C_B40] == 8'h52) begin
              push              = 1'b1;
              push_job.kind     = bfc_pkg::KIND_PHONE;
              push_job.last_idx = 4'd10;
              push_job.base_lo  = 6'd40;
              push_job.base_hi  = 6'd40;
            end
          end
          default: push = 1'b0;
        endcase
      end else if (len_19) begin
        // "Get:" prefix, then twelve MAC characters
        if (cap_r[C_B3] == 8'h47 && cap_r[C_B4] == 8'h65 &&
            cap_r[C_B5] == 8'h74 && cap_r[C_B6] == 8'h3A) begin
          push              = 1'b1;
          push_job.kind     = bfc_pkg::KIND_MAC;
          push_job.last_idx = 4'd11;
          push_job.base_lo  = 6'd7;
          push_job.base_hi  = 6'd7;
        end
      end else if (len_short) begin
        // "DIS", with "BE" behind it on the long form
        if (cap_r[C_B3] == 8'h44 && cap_r[C_B4] == 8'h49 &&
            cap_r[C_B5] == 8'h53 &&
            (count_r == CNT_W'(6) ||
             (cap_r[C_B6] == 8'h42 && cap_r[C_B7] == 8'h45))) begin
          push              = 1'b1;
          push_job.kind     = bfc_pkg::KIND_SCAN;
          push_job.last_idx = 4'd0;
        end
      end
    end
  end

  // Advance intake state; clear it after classification
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    eval_nxt  = eval_r;
    bank_nxt  = bank_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;
    for (int i = 0; i < CAP_NUM; i++) begin
      cap_nxt[i] = cap_r[i];
    end
    if (eval_r) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      eval_nxt  = 1'b0;
      bank_nxt  = bank_r ^ push;
      tail0_nxt = '0;
      tail1_nxt = '0;
      for (int i = 0; i < CAP_NUM; i++) begin
        cap_nxt[i] = '0;
      end
    end else if (accept) begin
      if (store) begin
        count_nxt = count_r + CNT_W'(1);
        tail0_nxt = tail1_r;
        tail1_nxt = in_rx_byte;
        for (int i = 0; i < CAP_NUM; i++) begin
          if (count_r == CNT_W'(CAP_POS[i])) begin
            cap_nxt[i] = in_rx_byte;
          end
        end
      end else begin
        ovf_nxt = 1'b1;
      end
      eval_nxt = in_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      eval_r  <= 1'b0;
      bank_r  <= 1'b0;
      tail0_r <= '0;
      tail1_r <= '0;
      for (int i = 0; i < CAP_NUM; i++) begin
        cap_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      eval_r  <= eval_nxt;
      bank_r  <= bank_nxt;
      tail0_r <= tail0_nxt;
      tail1_r <= tail1_nxt;
      for (int i = 0; i < CAP_NUM; i++) begin
        cap_r[i] <= cap_nxt[i];
      end
    end
  end

endmodule

/* hdl/bfc_queue.sv */
// ----------------------------------------------------------------------------
// bfc_queue - two-entry job queue
// Holds classified frames until the result sequencer has played them out.
// ----------------------------------------------------------------------------
module bfc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bfc_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output bfc_pkg::job_t q_job
);

  bfc_pkg::job_t slot_r [2];
  logic          wptr_r, wptr_nxt;
  logic          rptr_r, rptr_nxt;
  logic [1:0]    fill_r, fill_nxt;

  assign q_valid = (fill_r != 2'd0);
  assign q_full  = (fill_r == 2'd2);
  assign q_job   = slot_r[rptr_r];

  // Advance pointers and fill level
  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

/* hdl/bfc_back.sv */
// ----------------------------------------------------------------------------
// bfc_back - frame buffer and result sequencer
// Owns the two-bank frame buffer, walks the payload of the head job one byte
// per cycle and drives the result strobe.
// ----------------------------------------------------------------------------
module bfc_back #(
  parameter int FRAME_BYTES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [$clog2(FRAME_BYTES):0] wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         q_valid,
  input  bfc_pkg::job_t                q_job,
  output logic                         pop,
  output logic                         out_valid,
  output logic [2:0]                   out_msg_kind,
  output logic [3:0]                   out_byte_index,
  output logic [7:0]                   out_payload_byte,
  output logic                         out_run_last
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_r;

  logic [3:0]  cursor_r, cursor_nxt;
  logic [5:0]  base;
  logic [6:0]  offs;
  logic [IDX_W:0] rd_addr;
  logic        in_range;

  logic           s1_valid_r, s1_valid_nxt;
  bfc_pkg::kind_t s1_kind_r;
  logic [3:0]     s1_idx_r;
  logic           s1_last_r;
  logic           s1_inr_r;
  logic           ended_r, ended_nxt;

  logic       ended_eff;
  logic [7:0] raw_byte;
  logic [7:0] pay_nxt;

  logic           out_valid_r;
  bfc_pkg::kind_t out_kind_r;
  logic [3:0]     out_idx_r;
  logic [7:0]     out_pay_r;
  logic           out_last_r;

  // Issue one buffer read per cycle for the head job
  assign base = (cursor_r >= 4'(bfc_pkg::SPLIT_POS)) ? q_job.base_hi : q_job.base_lo;
  assign offs = {1'b0, base} + {3'b000, cursor_r};
  assign rd_addr = {q_job.bank, IDX_W'(offs)};
  assign in_range = (offs < {1'b0, q_job.len}) && (q_job.kind != bfc_pkg::KIND_SCAN);
  assign pop = q_valid && (cursor_r == q_job.last_idx);

  always_comb begin
    cursor_nxt = cursor_r;
    if (pop) begin
      cursor_nxt = 4'd0;
    end else if (q_valid) begin
      cursor_nxt = cursor_r + 4'd1;
    end
  end

  // Frame buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Form the payload byte; the time run turns to zero after its first zero
  assign ended_eff = ended_r && (s1_idx_r != 4'd0);
  assign raw_byte  = s1_inr_r ? rdata_r : 8'h00;
  always_comb begin
    pay_nxt   = raw_byte;
    ended_nxt = ended_r;
    if (s1_valid_r && s1_kind_r == bfc_pkg::KIND_TIME) begin
      pay_nxt   = ended_eff ? 8'h00 : raw_byte;
      ended_nxt = ended_eff || (raw_byte == 8'h00);
    end
  end

  assign s1_valid_nxt = q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= 4'd0;
      s1_valid_r  <= 1'b0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      s1_valid_r  <= s1_valid_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= s1_valid_r;
    end
  end

  // Carry result fields alongside the read
  always_ff @(posedge clk) begin
    s1_kind_r  <= q_job.kind;
    s1_idx_r   <= cursor_r;
    s1_last_r  <= pop;
    s1_inr_r   <= in_range;
    out_kind_r <= s1_kind_r;
    out_idx_r  <= s1_idx_r;
    out_pay_r  <= pay_nxt;
    out_last_r <= s1_last_r;
  end

  assign out_valid        = out_valid_r;
  assign out_msg_kind     = out_kind_r;
  assign out_byte_index   = out_idx_r;
  assign out_payload_byte = out_pay_r;
  assign out_run_last     = out_last_r;

endmodule

/* hdl/ble_uart_frame_classifier_unit.sv */
// ----------------------------------------------------------------------------
// ble_uart_frame_classifier_unit - radio UART frame classifier
// Buffers one frame, classifies it at frame end and plays out the extracted
// password, phone, time, MAC or scan-end result run.
// ----------------------------------------------------------------------------
//  channel  | transfer when      | ports
//  ---------+--------------------+---------------------------------------------
//  input    | start & !busy      | in_rx_byte, in_frame_end
//  result   | out_valid          | out_msg_kind, out_byte_index,
//           |                    | out_payload_byte, out_run_last
//
// Each byte is one input transfer; the frame-end byte is followed by a classify step.
// A run of n results (1 to 14) is classified, queued, read from the buffer and
// registered out, and streams one result per cycle from the buffer's read port.
// The buffer has two banks, so the next frame streams in while a run plays;
// busy holds off input during classify or while two classified frames pend.
// Reset is synchronous; no clearing pass is needed, a fill count masks stale
// bytes. The receiver takes every result; nothing stalls the result side.
// ----------------------------------------------------------------------------
module ble_uart_frame_classifier_unit #(
  parameter int FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  output logic [2:0] out_msg_kind,
  output logic [3:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic       out_run_last
);

  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic             wr_en;
  logic [IDX_W:0]   wr_addr;
  logic [7:0]       wr_data;
  logic             push;
  bfc_pkg::job_t    push_job;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  bfc_pkg::job_t    q_job;

  // Intake and classification
  bfc_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_rx_byte   (in_rx_byte),
    .in_frame_end (in_frame_end),
    .q_full       (q_full),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_job     (push_job)
  );

  // Pending jobs
  bfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  // Buffer and result sequencing
  bfc_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .q_valid          (q_valid),
    .q_job            (q_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_msg_kind     (out_msg_kind),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_run_last     (out_run_last)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the radio UART frame classifier
// Builds scan-end, MAC, password, phone and time frames, plus broken, noise
// and oversized ones, and sends them byte by byte with random gaps. A local
// frame model predicts every result run, and a monitor checks each result
// strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAME_BYTES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 360;
  localparam int TAIL_CYCLES = 40;

  // Frame framing and marker bytes
  localparam logic [7:0] HDR_BYTE     = 8'h4F;
  localparam logic [7:0] CR_BYTE      = 8'h0D;
  localparam logic [7:0] LF_BYTE      = 8'h0A;
  localparam logic [7:0] TYPE_PWD_A   = 8'h1A;
  localparam logic [7:0] TYPE_PHONE_A = 8'h0F;
  localparam logic [7:0] TYPE_TIME_A  = 8'h18;
  localparam logic [7:0] TYPE_PWD_B   = 8'h08;
  localparam logic [7:0] TYPE_TIME_B  = 8'h12;
  localparam logic [7:0] TYPE_PHONE_B = 8'h1E;
  localparam logic [15:0] PWD_A_TAG   = 16'h575A;
  localparam logic [15:0] PHONE_A_TAG = 16'h777A;
  localparam logic [15:0] TIME_A_TAG  = 16'h4954;
  localparam logic [15:0] PWD_B_TAG   = 16'h0709;
  localparam logic [15:0] TIME_B_TAG  = 16'h5449;
  localparam logic [7:0] PHONE_B_MARK = 8'h52;
  localparam logic [31:0] GET_TAG     = "Get:";
  localparam logic [23:0] DIS_TAG     = "DIS";
  localparam logic [15:0] BE_TAG      = "BE";

  typedef enum int {
    FR_SCAN6, FR_SCAN8, FR_MAC, FR_PWD_A, FR_PHONE_A, FR_TIME_A,
    FR_PWD_B, FR_TIME_B, FR_PHONE_B, FR_NOISE
  } frame_cls_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } rx_item_t;

  typedef struct {
    bfc_pkg::kind_t kind;
    logic [3:0]     idx;
    logic [7:0]     data;
    logic           last;
  } msg_rec_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic [2:0] out_msg_kind;
  logic [3:0] out_byte_index;
  logic [7:0] out_payload_byte;
  logic       out_run_last;

  rx_item_t   pending_bytes[$];
  msg_rec_t   expected_msgs[$];

  // Local copy of the frame buffer
  logic [7:0] frame_buf[FRAME_BYTES];
  int         fill_cnt = 0;
  bit         ovf_seen = 1'b0;

  int errors = 0;
  int cycles = 0;
  int bytes_total = 0;
  int bytes_sent = 0;
  int frames_built = 0;
  int frames_with_msgs = 0;
  int results_seen = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit calm = 1'b0;
  rx_item_t nxt_item;
  msg_rec_t want;

  ble_uart_frame_classifier_unit #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_rx_byte       (in_rx_byte),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_msg_kind     (out_msg_kind),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_run_last     (out_run_last)
  );

  always #10 clk = ~clk;

  // ------------------------------------------------------------------
  // Frame model
  // ------------------------------------------------------------------
  function automatic logic [7:0] buf_at(int i);
    if (i < FRAME_BYTES && i < fill_cnt) return frame_buf[i];
    return 8'h00;
  endfunction

  function automatic bit tag_at(int i, logic [15:0] tag);
    return buf_at(i) == tag[15:8] && buf_at(i + 1) == tag[7:0];
  endfunction

  function automatic void push_run(bfc_pkg::kind_t k, logic [7:0] src[14], int n);
    msg_rec_t r;
    for (int c = 0; c < n; c++) begin
      r.kind = k;
      r.idx  = 4'(c);
      r.data = src[c];
      r.last = (c == n - 1);
      expected_msgs.push_back(r);
    end
    frames_with_msgs++;
  endfunction

  // Copy a time string up to its first zero byte, zero from there on
  function automatic void push_time();
    logic [7:0] pl[14];
    bit ended;
    logic [7:0] c;
    ended = 1'b0;
    for (int i = 0; i < 14; i++) begin
      c = ended ? 8'h00 : buf_at(31 + i);
      if (c == 8'h00) ended = 1'b1;
      pl[i] = c;
    end
    push_run(bfc_pkg::KIND_TIME, pl, 14);
  endfunction

  function automatic void classify_frame();
    int len;
    logic [7:0] pl[14];
    len = fill_cnt;
    for (int i = 0; i < 14; i++) pl[i] = 8'h00;
    if (buf_at(0) != HDR_BYTE) return;
    if (len != 6 && len != 8 && len != 19) begin
      if (len < 2 || buf_at(len - 2) != CR_BYTE || buf_at(len - 1) != LF_BYTE) return;
    end
    case (len)
      37, 44, 47, 53, 55, 59: begin
        case (buf_at(26))
          TYPE_PWD_A: begin
            if (tag_at(29, PWD_A_TAG)) begin
              for (int i = 0; i < 6; i++) begin
                pl[i] = buf_at(31 + i);
                pl[i + 6] = buf_at(47 + i);
              end
              push_run(bfc_pkg::KIND_PWD, pl, 12);
            end
          end
          TYPE_PHONE_A: begin
            if (tag_at(29, PHONE_A_TAG)) begin
              for (int i = 0; i < 11; i++) pl[i] = buf_at(31 + i);
              push_run(bfc_pkg::KIND_PHONE, pl, 11);
            end
          end
          TYPE_TIME_A: if (tag_at(29, TIME_A_TAG)) push_time();
          TYPE_PWD_B: begin
            if (tag_at(27, PWD_B_TAG)) begin
              for (int i = 0; i < 6; i++) begin
                pl[i] = buf_at(29 + i);
                pl[i + 6] = buf_at(29 + i);
              end
              push_run(bfc_pkg::KIND_PWD, pl, 12);
            end
          end
          TYPE_TIME_B: if (tag_at(29, TIME_B_TAG)) push_time();
          TYPE_PHONE_B: begin
            if (buf_at(36) == 8'h00 && buf_at(37) == LF_BYTE && buf_at(40) == PHONE_B_MARK) begin
              for (int i = 0; i < 11; i++) pl[i] = buf_at(40 + i);
              push_run(bfc_pkg::KIND_PHONE, pl, 11);
            end
          end
          default: ;
        endcase
      end
      19: begin
        if (buf_at(3) == GET_TAG[31:24] && buf_at(4) == GET_TAG[23:16] &&
            buf_at(5) == GET_TAG[15:8] && buf_at(6) == GET_TAG[7:0]) begin
          for (int i = 0; i < 12; i++) pl[i] = buf_at(7 + i);
          push_run(bfc_pkg::KIND_MAC, pl, 12);
        end
      end
      6, 8: begin
        if (buf_at(3) == DIS_TAG[23:16] && buf_at(4) == DIS_TAG[15:8] &&
            buf_at(5) == DIS_TAG[7:0] && (len == 6 || tag_at(6, BE_TAG)))
          push_run(bfc_pkg::KIND_SCAN, pl, 1);
      end
      default: ;
    endcase
  endfunction

  // Store one accepted byte; classify and clear at frame end
  function automatic void absorb_byte(logic [7:0] b, logic last);
    if (fill_cnt < FRAME_BYTES) begin
      frame_buf[fill_cnt] = b;
      fill_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) begin
      if (!ovf_seen) classify_frame();
      fill_cnt = 0;
      ovf_seen = 1'b0;
    end
  endfunction

  // ------------------------------------------------------------------
  // Frame builder
  // ------------------------------------------------------------------
  function automatic int pick_long_len(bit no_short);
    case ($urandom_range(no_short ? 1 : 0, 5))
      0: return 37;
      1: return 44;
      2: return 47;
      3: return 53;
      4: return 55;
      default: return 59;
    endcase
  endfunction

  function automatic void put_tag(ref logic [7:0] fb[72], input int i, logic [15:0] tag);
    fb[i] = tag[15:8];
    fb[i + 1] = tag[7:0];
  endfunction

  // Build one frame of class cls; len 0 picks a fitting length, time_zero
  // plants a zero in the time string, bad_pos flips one byte
  task automatic make_frame(frame_cls_t cls, int len, int time_zero, int bad_pos, bit drain);
    logic [7:0] fb[72];
    rx_item_t it;
    if (len == 0) begin
      case (cls)
        FR_SCAN6:   len = 6;
        FR_SCAN8:   len = 8;
        FR_MAC:     len = 19;
        FR_PHONE_B: len = pick_long_len(1'b1);
        FR_NOISE:   len = $urandom_range(1, 70);
        default:    len = pick_long_len(1'b0);
      endcase
    end
    for (int i = 0; i < 72; i++) fb[i] = 8'($urandom_range(0, 255));
    case (cls)
      FR_SCAN6, FR_SCAN8: begin
        fb[3] = DIS_TAG[23:16];
        fb[4] = DIS_TAG[15:8];
        fb[5] = DIS_TAG[7:0];
        if (cls == FR_SCAN8) put_tag(fb, 6, BE_TAG);
      end
      FR_MAC: begin
        put_tag(fb, 3, GET_TAG[31:16]);
        put_tag(fb, 5, GET_TAG[15:0]);
      end
      FR_PWD_A:   begin fb[26] = TYPE_PWD_A;   put_tag(fb, 29, PWD_A_TAG);   end
      FR_PHONE_A: begin fb[26] = TYPE_PHONE_A; put_tag(fb, 29, PHONE_A_TAG); end
      FR_PWD_B:   begin fb[26] = TYPE_PWD_B;   put_tag(fb, 27, PWD_B_TAG);   end
      FR_TIME_A, FR_TIME_B: begin
        fb[26] = (cls == FR_TIME_A) ? TYPE_TIME_A : TYPE_TIME_B;
        put_tag(fb, 29, (cls == FR_TIME_A) ? TIME_A_TAG : TIME_B_TAG);
        for (int i = 31; i < 45; i++) fb[i] = 8'h30 + 8'($urandom_range(0, 9));
        if (time_zero >= 0) fb[time_zero] = 8'h00;
      end
      FR_PHONE_B: begin
        fb[26] = TYPE_PHONE_B;
        fb[36] = 8'h00;
        fb[37] = LF_BYTE;
        fb[40] = PHONE_B_MARK;
      end
      default: ;
    endcase
    // Header and CR LF tail; noise gets them only by chance
    if (cls != FR_NOISE || $urandom_range(0, 1)) fb[0] = HDR_BYTE;
    if (len != 6 && len != 8 && len != 19 && len >= 2 &&
        (cls != FR_NOISE || $urandom_range(0, 1))) begin
      fb[len - 2] = CR_BYTE;
      fb[len - 1] = LF_BYTE;
    end
    if (bad_pos >= 0) fb[bad_pos] = fb[bad_pos] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) begin
      it.data  = fb[i];
      it.last  = (i == len - 1);
      it.drain = drain && (i == 0);
      pending_bytes.push_back(it);
    end
    bytes_total += len;
    frames_built++;
  endtask

  // Sender gap per transfer: each burst has either no gaps or random gaps, picked at random
  function automatic int draw_gap();
    if (burst_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(4, 40);
    end
    burst_left--;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic report_mismatch(string what, int got, int want_val);
    if (errors < 60)
      $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want_val);
    errors++;
  endtask

  // ------------------------------------------------------------------
  // Driver: offer the next byte, hold it while busy
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        absorb_byte(in_rx_byte, in_frame_end);
        bytes_sent++;
      end
      if (start && busy) begin
        // hold the offered transfer
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_bytes.size() > 0 &&
                   !(pending_bytes[0].drain && expected_msgs.size() > 0)) begin
        nxt_item = pending_bytes.pop_front();
        in_rx_byte <= nxt_item.data;
        in_frame_end <= nxt_item.last;
        start <= 1'b1;
        gap_left <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: check every result strobe against the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_msgs.size() == 0) begin
        report_mismatch("result with none pending, kind", out_msg_kind, 0);
      end else begin
        want = expected_msgs.pop_front();
        if (out_msg_kind !== want.kind) report_mismatch("msg_kind", out_msg_kind, want.kind);
        if (out_byte_index !== want.idx) report_mismatch("byte_index", out_byte_index, want.idx);
        if (out_payload_byte !== want.data)
          report_mismatch("payload_byte", out_payload_byte, want.data);
        if (out_run_last !== want.last) report_mismatch("run_last", out_run_last, want.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still pending", cycles,
               expected_msgs.size());
      $display("** ble_uart_frame_classifier_unit: FAILED **");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus and end of run
  // ------------------------------------------------------------------
  initial begin
    frame_cls_t cls;
    int rnd_bytes;
    int bad;
    int tz;
    for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'h00;

    // Directed frames: each message kind, scan end both lengths, early
    // end of a time string, reads past the length, bad header, bad tail,
    // broken markers, a non-class length, an oversized frame, one byte
    make_frame(FR_SCAN6,   0, -1, -1, 1'b0);
    make_frame(FR_SCAN8,   0, -1, -1, 1'b0);
    make_frame(FR_SCAN8,   0, -1,  7, 1'b0);
    make_frame(FR_SCAN6,   0, -1,  0, 1'b0);
    make_frame(FR_MAC,     0, -1, -1, 1'b0);
    make_frame(FR_PWD_A,  37, -1, -1, 1'b0);
    make_frame(FR_PHONE_A, 37, -1, -1, 1'b0);
    make_frame(FR_TIME_A, 37, 35, -1, 1'b0);
    make_frame(FR_PWD_B,  37, -1, -1, 1'b0);
    make_frame(FR_PHONE_B, 44, -1, -1, 1'b0);
    make_frame(FR_TIME_B, 37, -1, 36, 1'b0);
    make_frame(FR_SCAN6,   7, -1, -1, 1'b0);
    make_frame(FR_PWD_A,  65, -1, -1, 1'b0);
    make_frame(FR_NOISE,   1, -1, -1, 1'b0);

    // Random frames: mostly well formed, some broken, some noise
    rnd_bytes = 0;
    for (int f = 0; rnd_bytes < RANDOM_BYTES; f++) begin
      cls = frame_cls_t'($urandom_range(0, 9));
      bad = -1;
      tz = -1;
      if (cls != FR_NOISE && $urandom_range(0, 5) == 0) bad = $urandom_range(0, 18);
      if ($urandom_range(0, 2) == 0) tz = $urandom_range(31, 44);
      make_frame(cls, 0, tz, bad, (f % 6) == 0);
      rnd_bytes = bytes_total - rnd_bytes + rnd_bytes;
      rnd_bytes = bytes_total;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent < bytes_total || expected_msgs.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d frames (%0d bytes); %0d frames produced runs, %0d result transfers.",
             frames_built, bytes_total, frames_with_msgs, results_seen);
    $display("Covered scan end, MAC, password, phone, time, broken, noise and oversized frames.");
    if (errors == 0) begin
      $display("** ble_uart_frame_classifier_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** ble_uart_frame_classifier_unit: FAILED **");
    end
    $finish;
  end

endmodule
